// File: hw/rtl/box_iou_threshold_scorer_assert.svh
// Assertion macros shared by the box overlap scorer RTL.
`ifndef BOX_IOU_THRESHOLD_SCORER_ASSERT_SVH
`define BOX_IOU_THRESHOLD_SCORER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIOU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIOU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/biou_pkg.sv
// Shared types and constants for the box overlap scorer.
package biou_pkg;

    localparam int unsigned COORD_BITS      = 16;
    localparam int unsigned SCORE_FRAC_BITS = 16;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned SCORE_W  = SCORE_FRAC_BITS + 1;
    localparam logic [SCORE_W-1:0] THRESH_RESET = 17'd29491;

    typedef struct packed {
        logic valid;
        logic ok;
        logic sat;
    } t_div_flags;

endpackage

// File: hw/rtl/biou_front.sv
// Front stages: edge selection, area products, union and divider setup.
module biou_front #(
    parameter int unsigned CW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [biou_pkg::FIELD_W-1:0] i_a_left,
    input  logic [biou_pkg::FIELD_W-1:0] i_a_top,
    input  logic [biou_pkg::FIELD_W-1:0] i_a_right,
    input  logic [biou_pkg::FIELD_W-1:0] i_a_bottom,
    input  logic [biou_pkg::FIELD_W-1:0] i_b_left,
    input  logic [biou_pkg::FIELD_W-1:0] i_b_top,
    input  logic [biou_pkg::FIELD_W-1:0] i_b_right,
    input  logic [biou_pkg::FIELD_W-1:0] i_b_bottom,
    output biou_pkg::t_div_flags        o_flags,
    output logic [2*CW+1:0]             o_num,
    output logic [2*CW+1:0]             o_den
);
    import biou_pkg::*;

    localparam int unsigned DW = 2 * CW + 2;
    localparam int unsigned UW = 2 * CW + 3;

    logic [CW-1:0]        al, at, ar, ab, bl, bt, br, bb;
    logic [CW-1:0]        xl, yt, xr, yb;
    logic                 n1_disj;
    logic [CW-1:0]        n1_iw, n1_ih;
    logic signed [CW:0]   n1_wa, n1_ha, n1_wb, n1_hb;

    logic                 r1_valid, r1_disj;
    logic [CW-1:0]        r1_iw, r1_ih;
    logic signed [CW:0]   r1_wa, r1_ha, r1_wb, r1_hb;

    logic                 r2_valid, r2_disj;
    logic signed [DW-1:0] r2_area_a, r2_area_b;
    logic [2*CW-1:0]      r2_inter;

    logic signed [UW-1:0] n3_uni;
    logic                 r3_valid, r3_disj;
    logic signed [UW-1:0] r3_uni;
    logic [2*CW-1:0]      r3_inter;

    t_div_flags           n4_flags;
    t_div_flags           r4_flags;
    logic [DW-1:0]        r4_num, r4_den;

    always_comb begin
        al = i_a_left[CW-1:0];
        at = i_a_top[CW-1:0];
        ar = i_a_right[CW-1:0];
        ab = i_a_bottom[CW-1:0];
        bl = i_b_left[CW-1:0];
        bt = i_b_top[CW-1:0];
        br = i_b_right[CW-1:0];
        bb = i_b_bottom[CW-1:0];
        xl = (al > bl) ? al : bl;
        yt = (at > bt) ? at : bt;
        xr = (ar < br) ? ar : br;
        yb = (ab < bb) ? ab : bb;
        n1_disj = (xr < xl) || (yb < yt);
        n1_iw = xr - xl;
        n1_ih = yb - yt;
        n1_wa = $signed({1'b0, ar}) - $signed({1'b0, al});
        n1_ha = $signed({1'b0, ab}) - $signed({1'b0, at});
        n1_wb = $signed({1'b0, br}) - $signed({1'b0, bl});
        n1_hb = $signed({1'b0, bb}) - $signed({1'b0, bt});
    end

    always_comb begin
        n3_uni = UW'(r2_area_a) + UW'(r2_area_b) - $signed(UW'(r2_inter));
    end

    always_comb begin
        n4_flags.valid = r3_valid;
        n4_flags.ok    = !r3_disj && !r3_uni[UW-1] && (r3_uni != '0);
        n4_flags.sat   = $signed(UW'(r3_inter)) >= r3_uni;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_flags <= '0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_flags <= n4_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_disj   <= n1_disj;
            r1_iw     <= n1_iw;
            r1_ih     <= n1_ih;
            r1_wa     <= n1_wa;
            r1_ha     <= n1_ha;
            r1_wb     <= n1_wb;
            r1_hb     <= n1_hb;
            r2_disj   <= r1_disj;
            r2_area_a <= r1_wa * r1_ha;
            r2_area_b <= r1_wb * r1_hb;
            r2_inter  <= r1_iw * r1_ih;
            r3_disj   <= r2_disj;
            r3_uni    <= n3_uni;
            r3_inter  <= r2_inter;
            r4_num    <= DW'(r3_inter);
            r4_den    <= r3_uni[DW-1:0];
        end
    end

    assign o_flags = r4_flags;
    assign o_num   = r4_num;
    assign o_den   = r4_den;

endmodule

// File: hw/rtl/biou_div_cell.sv
// One restoring-division cell: produces one quotient bit per item.
module biou_div_cell #(
    parameter int unsigned DW = 34,
    parameter int unsigned SF = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  biou_pkg::t_div_flags i_flags,
    input  logic [DW-1:0]        i_rem,
    input  logic [DW-1:0]        i_den,
    input  logic [SF-1:0]        i_quo,
    output biou_pkg::t_div_flags o_flags,
    output logic [DW-1:0]        o_rem,
    output logic [DW-1:0]        o_den,
    output logic [SF-1:0]        o_quo
);
    import biou_pkg::*;

    logic [DW:0]   shifted;
    logic          take;
    logic [DW:0]   n_rem_full;

    t_div_flags    r_flags;
    logic [DW-1:0] r_rem, r_den;
    logic [SF-1:0] r_quo;

    always_comb begin
        shifted    = {i_rem, 1'b0};
        take       = shifted >= {1'b0, i_den};
        n_rem_full = take ? (shifted - {1'b0, i_den}) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_adv) begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= n_rem_full[DW-1:0];
            r_den <= i_den;
            r_quo <= {i_quo[SF-2:0], take};
        end
    end

    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;

endmodule

// File: hw/rtl/box_iou_threshold_scorer.sv
// Box intersection-over-union scorer with a programmable score threshold.
//
// Input channel: i_in_valid / o_in_stall with the eight box edges. A word is
// taken at a clock edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_score and o_overlapping.
// Config channel: i_cfg_valid / o_cfg_ready with the 17-bit threshold; it is
// always ready and should only be written while no word is in flight.
// The pipeline holds four front stages, one divider cell per quotient bit
// and the output register; it takes one word per cycle while o_in_stall
// is low, and every divider cell holds a different word.
// A stall at the output fills a one-word skid register; the whole pipeline
// then freezes and o_in_stall rises until the skid register drains.
// Reset clears all valid flags and loads the threshold with 0.45 in Q1.16.
module box_iou_threshold_scorer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [biou_pkg::FIELD_W-1:0]  i_a_left,
    input  logic [biou_pkg::FIELD_W-1:0]  i_a_top,
    input  logic [biou_pkg::FIELD_W-1:0]  i_a_right,
    input  logic [biou_pkg::FIELD_W-1:0]  i_a_bottom,
    input  logic [biou_pkg::FIELD_W-1:0]  i_b_left,
    input  logic [biou_pkg::FIELD_W-1:0]  i_b_top,
    input  logic [biou_pkg::FIELD_W-1:0]  i_b_right,
    input  logic [biou_pkg::FIELD_W-1:0]  i_b_bottom,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [biou_pkg::SCORE_W-1:0]  o_score,
    output logic                          o_overlapping,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [biou_pkg::SCORE_W-1:0]  i_cfg_data
);
    import biou_pkg::*;

    localparam int unsigned CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int unsigned DW = 2 * CW + 2;
    localparam int unsigned SF = SCORE_FRAC_BITS;
    localparam int unsigned SW = SF + 1;
    localparam int unsigned TW = (SW > SCORE_W) ? SW : SCORE_W;

    logic               adv;
    logic               in_take;
    logic               out_take;

    t_div_flags         chain_flags [SF+1];
    logic [DW-1:0]      chain_rem   [SF+1];
    logic [DW-1:0]      chain_den   [SF+1];
    logic [SF-1:0]      chain_quo   [SF+1];

    logic [SCORE_W-1:0] r_thresh;
    logic [SW-1:0]      fin_score;
    logic [TW-1:0]      fin_score_ext;
    logic [TW-1:0]      fin_kept;
    logic [SCORE_W-1:0] fin_out;
    logic               fin_ovl;

    logic               r_ov, r_sv;
    logic [SCORE_W-1:0] r_o_score, r_s_score;
    logic               r_o_ovl, r_s_ovl;

    assign adv        = !r_sv;
    assign o_in_stall = r_sv;
    assign in_take    = i_in_valid && adv;
    assign out_take   = r_ov && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    biou_front #(
        .CW (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (in_take),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_right  (i_a_right),
        .i_a_bottom (i_a_bottom),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_right  (i_b_right),
        .i_b_bottom (i_b_bottom),
        .o_flags    (chain_flags[0]),
        .o_num      (chain_rem[0]),
        .o_den      (chain_den[0])
    );

    assign chain_quo[0] = '0;

    for (genvar g = 0; g < SF; g++) begin : g_cell
        biou_div_cell #(
            .DW (DW),
            .SF (SF)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_flags (chain_flags[g]),
            .i_rem   (chain_rem[g]),
            .i_den   (chain_den[g]),
            .i_quo   (chain_quo[g]),
            .o_flags (chain_flags[g+1]),
            .o_rem   (chain_rem[g+1]),
            .o_den   (chain_den[g+1]),
            .o_quo   (chain_quo[g+1])
        );
    end

    always_comb begin
        fin_score     = chain_flags[SF].sat ? (SW'(1) << SF) : {1'b0, chain_quo[SF]};
        fin_score_ext = TW'(fin_score);
        fin_ovl       = chain_flags[SF].ok;
        if (!fin_ovl || (fin_score_ext < TW'(r_thresh))) begin
            fin_kept = '0;
        end else begin
            fin_kept = fin_score_ext;
        end
        fin_out = fin_kept[SCORE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (out_take) begin
                r_sv <= 1'b0;
            end
        end else if (chain_flags[SF].valid) begin
            if (r_ov && !out_take) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (out_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_take) begin
                r_o_score <= r_s_score;
                r_o_ovl   <= r_s_ovl;
            end
        end else if (chain_flags[SF].valid) begin
            if (r_ov && !out_take) begin
                r_s_score <= fin_out;
                r_s_ovl   <= fin_ovl;
            end else begin
                r_o_score <= fin_out;
                r_o_ovl   <= fin_ovl;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_score       = r_o_score;
    assign o_overlapping = r_o_ovl;

`include "box_iou_threshold_scorer_assert.svh"

    `BIOU_ASSERT_SAME(a_skid_needs_out, r_sv, r_ov, "skid word held without an output word")
    `BIOU_ASSERT_SAME(a_score_implies_ovl, o_out_valid && (o_score != '0), o_overlapping,
        "nonzero score on a pair that does not overlap")
    `BIOU_ASSERT_NEXT(a_skid_holds, r_sv && i_out_stall, r_sv && o_in_stall,
        "skid word dropped while the output is stalled")

endmodule
